[rtl/core/dfps_pkg.sv]
// ----------------------------------------------------------------------------
// dfps_pkg: shared types and constants of the page transfer sequencer
// Request and result structs, action codes, flash opcodes and address setup.
// ----------------------------------------------------------------------------
`default_nettype none

package dfps_pkg;

  // Request actions.
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_PROGRAM = 2'd1;
  localparam logic [1:0] ACT_XFER    = 2'd2;

  // Flash opcodes and status bits.
  localparam logic [7:0] OP_PROGRAM   = 8'h82;
  localparam logic [7:0] OP_READ      = 8'hD2;
  localparam logic [7:0] OP_STATUS    = 8'hD7;
  localparam logic [7:0] STATUS_READY = 8'h08;

  // Number of dummy bytes between the address and read data (0 to 8).
  localparam int DUMMY_BYTES = 4;
  // Number of page bits that reach the address (1 to 9; larger values keep all 9 bits).
  localparam int PAGE_BITS   = 9;

  localparam logic [8:0] PAGE_MASK =
    (PAGE_BITS >= 9) ? 9'h1FF : 9'((32'd1 << PAGE_BITS) - 32'd1);
  localparam logic [3:0] DUMMY_LAST = 4'(DUMMY_BYTES);

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] page;
    logic [8:0] buffer_offset;
    logic [9:0] byte_count;
    logic [7:0] rx_byte;
    logic [7:0] wr_byte;
  } cmd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/dataflash_page_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// dataflash_page_transfer_sequencer: SPI page read and program sequencer
// Polls flash status, then sends opcode, address, dummy and data bytes.
// ----------------------------------------------------------------------------
// Every accepted request yields exactly one result. A start request (page
// read or page program) opens a status poll frame; each later request reports
// one finished byte exchange and the result says what the SPI shifter does
// next: the byte to send, chip select framing, a read data byte, or the end
// of the transfer. A start while a transfer runs comes back with rejected set
// and changes nothing. The block takes one request per clock unless the input
// stalls: a request is held in the input register, the state update and
// result are computed from it and written to a two-entry result buffer, so a
// result passes through the input register and the result buffer before it
// reaches the output. The input stalls only when the result buffer is full
// and the input register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module dataflash_page_transfer_sequencer
  import dfps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  // Input register.
  cmd_t  item;
  logic  item_valid;
  logic  space;
  logic  advance;
  logic  accept;
  res_t  step_res;

  // The held request moves on whenever the result buffer has a free slot.
  assign advance   = item_valid && space;
  assign cmd_stall = item_valid && !space;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
  end

  // Transfer state and the step logic.
  dfps_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (step_res)
  );

  // Results are registered here and held while the receiver stalls.
  dfps_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_res),
    .space     (space),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

[rtl/core/dfps_seq.sv]
// ----------------------------------------------------------------------------
// dfps_seq: transfer state and one-step update logic
// Holds the transfer state and computes the result of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module dfps_seq
  import dfps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire cmd_t item,
  output res_t      result
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_POLL_CMD  = 3'd1,
    PH_POLL_STAT = 3'd2,
    PH_ADDR      = 3'd3,
    PH_DUMMY     = 3'd4,
    PH_DATA      = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic        is_write, is_write_next;
  logic [8:0]  page_reg, page_reg_next;
  logic [8:0]  offset_reg, offset_reg_next;
  logic [9:0]  bytes_left, bytes_left_next;
  logic [2:0]  step_index, step_index_next;

  logic        busy;
  logic [23:0] addr;
  logic [9:0]  data_left;
  logic        enter_data;

  assign busy = (phase != PH_IDLE);
  assign addr = {6'd0, page_reg & PAGE_MASK, offset_reg};

  always_comb begin
    result          = '0;
    phase_next      = phase;
    is_write_next   = is_write;
    page_reg_next   = page_reg;
    offset_reg_next = offset_reg;
    bytes_left_next = bytes_left;
    step_index_next = step_index;
    enter_data      = 1'b0;
    data_left       = bytes_left;

    if (item.action == ACT_READ || item.action == ACT_PROGRAM) begin
      if (busy) begin
        result.rejected = 1'b1;
      end else begin
        is_write_next      = item.action[0];
        page_reg_next      = item.page;
        offset_reg_next    = item.buffer_offset;
        bytes_left_next    = item.byte_count;
        step_index_next    = 3'd0;
        phase_next         = PH_POLL_CMD;
        result.tx_valid    = 1'b1;
        result.tx_byte     = OP_STATUS;
        result.frame_start = 1'b1;
      end
    end else if (item.action == ACT_XFER && busy) begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_POLL_CMD: begin
          result.tx_valid = 1'b1;
          phase_next      = PH_POLL_STAT;
        end
        PH_POLL_STAT: begin
          result.frame_end   = 1'b1;
          result.tx_valid    = 1'b1;
          result.frame_start = 1'b1;
          if ((item.rx_byte & STATUS_READY) != 8'd0) begin
            result.tx_byte  = is_write ? OP_PROGRAM : OP_READ;
            phase_next      = PH_ADDR;
            step_index_next = 3'd0;
          end else begin
            result.tx_byte = OP_STATUS;
            phase_next     = PH_POLL_CMD;
          end
        end
        PH_ADDR: begin
          if (step_index < 3'd3) begin
            step_index_next = step_index + 3'd1;
            result.tx_valid = 1'b1;
            unique case (step_index)
              3'd0:    result.tx_byte = addr[23:16];
              3'd1:    result.tx_byte = addr[15:8];
              default: result.tx_byte = addr[7:0];
            endcase
          end else begin
            step_index_next = 3'd0;
            if (!is_write && DUMMY_BYTES > 0) begin
              result.tx_valid = 1'b1;
              phase_next      = PH_DUMMY;
            end else begin
              enter_data = 1'b1;
            end
          end
        end
        PH_DUMMY: begin
          if (({1'b0, step_index} + 4'd1) < DUMMY_LAST) begin
            step_index_next = step_index + 3'd1;
            result.tx_valid = 1'b1;
          end else begin
            step_index_next = 3'd0;
            enter_data      = 1'b1;
          end
        end
        PH_DATA: begin
          if (!is_write) begin
            result.rd_valid = 1'b1;
            result.rd_data  = item.rx_byte;
          end
          data_left       = bytes_left - 10'd1;
          bytes_left_next = data_left;
          enter_data      = 1'b1;
        end
        default: begin
        end
      endcase

      // Either another data exchange or the close of the frame.
      if (enter_data) begin
        if (data_left == 10'd0) begin
          result.frame_end = 1'b1;
          result.done_res  = 1'b1;
          phase_next       = PH_IDLE;
          step_index_next  = 3'd0;
        end else begin
          result.tx_valid = 1'b1;
          result.tx_byte  = is_write ? item.wr_byte : 8'd0;
          phase_next      = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      is_write   <= 1'b0;
      page_reg   <= 9'd0;
      offset_reg <= 9'd0;
      bytes_left <= 10'd0;
      step_index <= 3'd0;
    end else if (step) begin
      phase      <= phase_next;
      is_write   <= is_write_next;
      page_reg   <= page_reg_next;
      offset_reg <= offset_reg_next;
      bytes_left <= bytes_left_next;
      step_index <= step_index_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dfps_res_buf.sv]
// ----------------------------------------------------------------------------
// dfps_res_buf: two-entry result buffer
// Registers results and holds them while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module dfps_res_buf
  import dfps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      space,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  res_t       slot0, slot1;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign res_valid = (count != 2'd0);
  assign pop       = res_valid && !res_stall;
  assign res       = rd_ptr ? slot1 : slot0;

  always_ff @(posedge clk) begin
    if (push && !wr_ptr) begin
      slot0 <= push_data;
    end
    if (push && wr_ptr) begin
      slot1 <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

[tb/sv/dataflash_page_transfer_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// dataflash_page_transfer_sequencer_tb: self-checking bench for the sequencer
// Drives status poll, address, dummy and data exchanges through the request
// channel. Each result is checked against a cycle-free behavioral prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dataflash_page_transfer_sequencer_tb;
  import dfps_pkg::*;

  // Where the predicted sequencer stands between requests.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_STATUS_CMD,
    SEQ_STATUS_READ,
    SEQ_ADDRESS,
    SEQ_DUMMY,
    SEQ_DATA
  } seq_phase_t;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  dataflash_page_transfer_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates in percent per cycle for the sender and the result receiver.
  // While hold_on is set the receiver stalls without a break.
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  logic hold_on       = 1'b0;

  int   mismatches    = 0;
  int   results_seen  = 0;
  int   requests_sent = 0;

  // Predicted state of the sequencer, updated once per accepted request.
  seq_phase_t  seq_phase  = SEQ_IDLE;
  logic        seq_write  = 1'b0;
  logic [8:0]  seq_page   = '0;
  logic [8:0]  seq_offset = '0;
  logic [9:0]  seq_left   = '0;
  logic [2:0]  seq_step   = '0;

  // Results that accepted requests still owe, oldest first.
  res_t pending_responses[$];
  res_t want;

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // After the address (and for a read the dummy bytes), either shift the
  // next data byte or, with nothing left, close the frame and finish.
  function automatic void open_data_or_finish(inout res_t r, input logic [7:0] wr);
    if (seq_left == 10'd0) begin
      r.frame_end = 1'b1;
      r.done_res  = 1'b1;
      seq_phase   = SEQ_IDLE;
      seq_step    = 3'd0;
    end else begin
      r.tx_valid = 1'b1;
      r.tx_byte  = seq_write ? wr : 8'h00;
      seq_phase  = SEQ_DATA;
    end
  endfunction

  // Works out the one result that a request causes and advances the state.
  function automatic res_t next_response(input cmd_t c);
    res_t        r;
    logic [23:0] flash_addr;
    r = '0;
    flash_addr = {6'd0, seq_page & PAGE_MASK, seq_offset};
    if (c.action == ACT_READ || c.action == ACT_PROGRAM) begin
      if (seq_phase != SEQ_IDLE) begin
        // A start while a transfer runs changes nothing.
        r.rejected = 1'b1;
      end else begin
        seq_write     = (c.action == ACT_PROGRAM);
        seq_page      = c.page;
        seq_offset    = c.buffer_offset;
        seq_left      = c.byte_count;
        seq_step      = 3'd0;
        seq_phase     = SEQ_STATUS_CMD;
        r.tx_valid    = 1'b1;
        r.tx_byte     = OP_STATUS;
        r.frame_start = 1'b1;
      end
    end else if (c.action == ACT_XFER && seq_phase != SEQ_IDLE) begin
      case (seq_phase)
        SEQ_STATUS_CMD: begin
          // The status byte arrives during the exchange of a zero byte.
          r.tx_valid = 1'b1;
          r.tx_byte  = 8'h00;
          seq_phase  = SEQ_STATUS_READ;
        end
        SEQ_STATUS_READ: begin
          // Every poll ends its frame; the next frame is either another
          // poll or the real command.
          r.frame_end   = 1'b1;
          r.frame_start = 1'b1;
          r.tx_valid    = 1'b1;
          if ((c.rx_byte & STATUS_READY) != 8'h00) begin
            r.tx_byte = seq_write ? OP_PROGRAM : OP_READ;
            seq_phase = SEQ_ADDRESS;
            seq_step  = 3'd0;
          end else begin
            r.tx_byte = OP_STATUS;
            seq_phase = SEQ_STATUS_CMD;
          end
        end
        SEQ_ADDRESS: begin
          if (seq_step < 3'd3) begin
            seq_step   = seq_step + 3'd1;
            r.tx_valid = 1'b1;
            case (seq_step)
              3'd1:    r.tx_byte = flash_addr[23:16];
              3'd2:    r.tx_byte = flash_addr[15:8];
              default: r.tx_byte = flash_addr[7:0];
            endcase
          end else begin
            seq_step = 3'd0;
            if (!seq_write && DUMMY_BYTES > 0) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = 8'h00;
              seq_phase  = SEQ_DUMMY;
            end else begin
              open_data_or_finish(r, c.wr_byte);
            end
          end
        end
        SEQ_DUMMY: begin
          if (int'(seq_step) + 1 < DUMMY_BYTES) begin
            seq_step   = seq_step + 3'd1;
            r.tx_valid = 1'b1;
            r.tx_byte  = 8'h00;
          end else begin
            seq_step = 3'd0;
            open_data_or_finish(r, c.wr_byte);
          end
        end
        default: begin
          // Data phase: a read hands back the byte that just came in.
          if (!seq_write) begin
            r.rd_valid = 1'b1;
            r.rd_data  = c.rx_byte;
          end
          seq_left = seq_left - 10'd1;
          open_data_or_finish(r, c.wr_byte);
        end
      endcase
    end
    // Exchange reports while idle and the unused action give an empty result.
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
  endtask

  // Requests are predicted and results checked at the rising edge, where both
  // channels see the values that were settled since the falling edge. A
  // result always trails its request, so predicting first is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall)
        pending_responses.push_back(next_response(cmd));
      if (res_valid && !res_stall) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = pending_responses.pop_front();
          compare_field("tx_valid",    8'(res.tx_valid),    8'(want.tx_valid));
          compare_field("tx_byte",     res.tx_byte,         want.tx_byte);
          compare_field("frame_start", 8'(res.frame_start), 8'(want.frame_start));
          compare_field("frame_end",   8'(res.frame_end),   8'(want.frame_end));
          compare_field("rd_valid",    8'(res.rd_valid),    8'(want.rd_valid));
          compare_field("rd_data",     res.rd_data,         want.rd_data);
          compare_field("done_res",    8'(res.done_res),    8'(want.done_res));
          compare_field("rejected",    8'(res.rejected),    8'(want.rejected));
        end
        results_seen++;
      end
    end
  end

  // The receiver stalls at random, or without a break during a hold-off.
  always @(negedge clk) begin
    if (rst)
      res_stall <= 1'b0;
    else if (hold_on)
      res_stall <= 1'b1;
    else
      res_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  function automatic cmd_t random_request(input logic [1:0] act);
    cmd_t c;
    c.action        = act;
    c.page          = 9'($urandom_range(511));
    c.buffer_offset = 9'($urandom_range(511));
    c.byte_count    = 10'($urandom_range(1023));
    c.rx_byte       = 8'($urandom_range(255));
    c.wr_byte       = 8'($urandom_range(255));
    return c;
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid stays
  // high afterwards, so back-to-back requests need no gap; an idle cycle
  // lowers it and fills the payload with junk.
  task automatic send_request(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_valid <= 1'b0;
      cmd       <= random_request(2'($urandom_range(3)));
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall)
      @(posedge clk);
    requests_sent++;
  endtask

  // Now and then slips in a request that must not disturb a running
  // transfer: a second start, which is rejected, or the unused action.
  task automatic maybe_noise(input int pct);
    if ($urandom_range(99) < pct) begin
      if ($urandom_range(1) == 0)
        send_request(random_request($urandom_range(1) ? ACT_PROGRAM : ACT_READ));
      else
        send_request(random_request(ACT_UNUSED));
    end
  endtask

  // One complete, well-formed transfer: start, a number of status polls that
  // find the flash busy, one that finds it ready, then exactly as many
  // exchange reports as the opcode, address, dummy and data bytes need.
  task automatic run_transfer(input logic [1:0] op, input logic [8:0] page,
                              input logic [8:0] offset, input logic [9:0] count,
                              input int busy_polls, input int noise_pct);
    cmd_t c;
    int   exchanges;
    c = random_request(op);
    c.page          = page;
    c.buffer_offset = offset;
    c.byte_count    = count;
    send_request(c);
    repeat (busy_polls) begin
      maybe_noise(noise_pct);
      send_request(random_request(ACT_XFER));
      maybe_noise(noise_pct);
      c = random_request(ACT_XFER);
      c.rx_byte = c.rx_byte & ~STATUS_READY;
      send_request(c);
    end
    maybe_noise(noise_pct);
    send_request(random_request(ACT_XFER));
    c = random_request(ACT_XFER);
    c.rx_byte = c.rx_byte | STATUS_READY;
    send_request(c);
    exchanges = 4 + ((op == ACT_READ) ? DUMMY_BYTES : 0) + int'(count);
    repeat (exchanges) begin
      maybe_noise(noise_pct);
      send_request(random_request(ACT_XFER));
    end
  endtask

  // The sender stops offering and holds back until every result owed has
  // come out.
  task automatic wait_all_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_responses.size() != 0)
      @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Requests while idle, a zero-length read at the top page and offset, and
  // a one-byte program at page zero that first finds the flash busy and gets
  // a second start thrown at it.
  task automatic test_directed();
    cmd_t c;
    send_request(random_request(ACT_XFER));
    send_request(random_request(ACT_UNUSED));
    run_transfer(ACT_READ, 9'h1FF, 9'h1FF, 10'd0, 0, 0);
    c = random_request(ACT_PROGRAM);
    c.page          = 9'd0;
    c.buffer_offset = 9'd0;
    c.byte_count    = 10'd1;
    send_request(c);
    send_request(random_request(ACT_READ));
    // Exchange 1 reads a busy status, 3 a ready one with nothing else set,
    // 7 leaves the address and programs an all-ones byte, 8 finishes.
    for (int i = 0; i < 9; i++) begin
      c = random_request(ACT_XFER);
      if (i == 1) c.rx_byte = 8'hF7;
      if (i == 3) c.rx_byte = STATUS_READY;
      if (i == 7) c.wr_byte = 8'hFF;
      send_request(c);
    end
    wait_all_results();
  endtask

  // Mostly short transfers of random content, a few long ones, with stray
  // requests between and inside them.
  task automatic test_random_traffic(input int n_requests);
    int         target;
    logic [1:0] op;
    logic [9:0] count;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 15) begin
        send_request(random_request($urandom_range(1) ? ACT_XFER : ACT_UNUSED));
      end else begin
        op    = $urandom_range(1) ? ACT_PROGRAM : ACT_READ;
        count = ($urandom_range(19) == 0) ? 10'($urandom_range(300, 64))
                                          : 10'($urandom_range(10));
        run_transfer(op, 9'($urandom_range(511)), 9'($urandom_range(511)), count,
                     ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0, 8);
      end
    end
    wait_all_results();
  endtask

  // A program of the largest byte count the field allows.
  task automatic test_full_page();
    run_transfer(ACT_PROGRAM, 9'($urandom_range(511)), 9'($urandom_range(511)),
                 10'h3FF, 0, 2);
    wait_all_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering requests, so the result buffer fills and the input stalls.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_on = 1'b1;
        repeat (300) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    run_transfer(ACT_READ, 9'($urandom_range(511)), 9'($urandom_range(511)),
                 10'd30, 1, 10);
    wait_all_results();
  endtask

  // ------------------------------------------------------------------------
  // Run
  // ------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 22;
    sink_idle_pct = 79;
    test_directed();
    test_random_traffic(60);

    src_idle_pct  = 79;
    sink_idle_pct = 22;
    test_random_traffic(60);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(60);
    test_full_page();
    test_backpressure();

    @(negedge clk);
    cmd_valid <= 1'b0;
    wait_all_results();
    // A result trails its request; give stray ones time to come out.
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // A time limit far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
